>>> rtl/vpt_pkg.sv
// Shared types, command codes and register defaults of the vehicle performance timer.
package vpt_pkg;

  localparam int KIND_W   = 3;
  localparam int DT_W     = 16;
  localparam int SPEED_W  = 18;
  localparam int PROD_W   = DT_W + SPEED_W;
  localparam int DIST_W   = 48;
  localparam int OUT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIST_W;

  localparam int TIME_BITS_DEF = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESET_RUN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START_WATCH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP_WATCH  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET_WATCH = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SPLIT       = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNSPLIT     = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MARK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MARK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_MARK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 3'd4;

  localparam logic [SPEED_W-1:0] START_SPEED_RST = 18'd500;
  localparam logic [SPEED_W-1:0] FIRST_MARK_RST  = 18'd27777;
  localparam logic [SPEED_W-1:0] SECOND_MARK_RST = 18'd55555;
  localparam logic [SPEED_W-1:0] THIRD_MARK_RST  = 18'd83333;
  localparam logic [DIST_W-1:0]  DIST_LIMIT_RST  = 48'd402336000000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DT_W-1:0]    elapsed_us;
    logic [SPEED_W-1:0] speed_mm_s;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] time_to_first;
    logic [OUT_W-1:0] time_to_second;
    logic [OUT_W-1:0] time_to_third;
    logic [OUT_W-1:0] time_first_to_second;
    logic [OUT_W-1:0] time_first_to_third;
    logic [OUT_W-1:0] time_second_to_third;
    logic [OUT_W-1:0] quarter_mile_time;
    logic [OUT_W-1:0] stopwatch_time;
    logic             run_active;
    logic [3:0]       marks_done;
    logic             stopwatch_active;
  } out_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] start_speed;
    logic [SPEED_W-1:0] first_speed_mark;
    logic [SPEED_W-1:0] second_speed_mark;
    logic [SPEED_W-1:0] third_speed_mark;
    logic [DIST_W-1:0]  distance_limit;
  } run_cfg_t;

endpackage

>>> rtl/vpt_run.sv
// Run timers: arming, interval timers, difference timers, speed marks and distance.
module vpt_run #(
  parameter int TIME_BITS = vpt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  vpt_pkg::in_word_t             word,
  input  logic [vpt_pkg::PROD_W-1:0]    prod,
  input  vpt_pkg::run_cfg_t             cfg,
  output logic [TIME_BITS-1:0]          times_nxt [7],
  output logic                          running_nxt,
  output logic [3:0]                    done_nxt
);
  import vpt_pkg::*;

  logic                 armed_r, armed_nxt;
  logic                 running_r;
  logic [TIME_BITS-1:0] times_r [7];
  logic [3:0]           done_r;
  logic [DIST_W-1:0]    dist_r, dist_nxt;

  logic [TIME_BITS-1:0] dt_w;
  logic [DIST_W:0]      dist_sum;
  logic                 go;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_sub(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  assign dt_w     = TIME_BITS'(word.elapsed_us);
  assign dist_sum = {1'b0, dist_r} + (DIST_W + 1)'(prod);
  assign go       = armed_r && (word.speed_mm_s > cfg.start_speed);

  always_comb begin
    armed_nxt   = armed_r;
    running_nxt = running_r;
    times_nxt   = times_r;
    done_nxt    = done_r;
    dist_nxt    = dist_r;
    unique case (word.kind)
      KIND_TICK: begin
        if (go) begin
          armed_nxt   = 1'b0;
          running_nxt = 1'b1;
        end
        if (running_r || go) begin
          if (!done_r[0]) begin
            times_nxt[0] = sat_add(times_r[0], dt_w);
          end
          if (!done_r[1]) begin
            times_nxt[1] = sat_add(times_r[1], dt_w);
            times_nxt[3] = sat_sub(times_nxt[1], times_nxt[0]);
          end
          if (!done_r[2]) begin
            times_nxt[2] = sat_add(times_r[2], dt_w);
            times_nxt[4] = sat_sub(times_nxt[2], times_nxt[0]);
            times_nxt[5] = sat_sub(times_nxt[2], times_nxt[1]);
          end
          if (!done_r[3]) begin
            times_nxt[6] = sat_add(times_r[6], dt_w);
          end
          if (word.speed_mm_s > cfg.first_speed_mark) begin
            done_nxt[0] = 1'b1;
          end
          if (word.speed_mm_s > cfg.second_speed_mark) begin
            done_nxt[1] = 1'b1;
          end
          if (word.speed_mm_s > cfg.third_speed_mark) begin
            done_nxt[2] = 1'b1;
          end
          dist_nxt = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
          if (dist_nxt > cfg.distance_limit) begin
            done_nxt[3] = 1'b1;
          end
        end
      end
      KIND_RESET_RUN: begin
        armed_nxt   = 1'b1;
        running_nxt = 1'b0;
        for (int i = 0; i < 7; i++) begin
          times_nxt[i] = '0;
        end
        done_nxt = '0;
        dist_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b1;
      running_r <= 1'b0;
      for (int i = 0; i < 7; i++) begin
        times_r[i] <= '0;
      end
      done_r <= '0;
      dist_r <= '0;
    end else if (fire) begin
      armed_r   <= armed_nxt;
      running_r <= running_nxt;
      times_r   <= times_nxt;
      done_r    <= done_nxt;
      dist_r    <= dist_nxt;
    end
  end

endmodule

>>> rtl/vpt_watch.sv
// Stopwatch with start, stop, reset, split and unsplit.
module vpt_watch #(
  parameter int TIME_BITS = vpt_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  vpt_pkg::in_word_t    word,
  output logic [TIME_BITS-1:0] time_nxt,
  output logic                 running_nxt
);
  import vpt_pkg::*;

  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS-1:0] offset_r, offset_nxt;
  logic                 running_r;
  logic                 split_r, split_nxt;
  logic [TIME_BITS-1:0] dt_w;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  assign dt_w = TIME_BITS'(word.elapsed_us);

  always_comb begin
    time_nxt    = time_r;
    offset_nxt  = offset_r;
    running_nxt = running_r;
    split_nxt   = split_r;
    unique case (word.kind)
      KIND_TICK: begin
        if (running_r) begin
          if (!split_r) begin
            // The time banked while split is folded back in first.
            time_nxt   = sat_add(sat_add(time_r, offset_r), dt_w);
            offset_nxt = '0;
          end else begin
            offset_nxt = sat_add(offset_r, dt_w);
          end
        end
      end
      KIND_START_WATCH: running_nxt = 1'b1;
      KIND_STOP_WATCH:  running_nxt = 1'b0;
      KIND_RESET_WATCH: begin
        running_nxt = 1'b0;
        time_nxt    = '0;
      end
      KIND_SPLIT:   split_nxt = 1'b1;
      KIND_UNSPLIT: split_nxt = 1'b0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      offset_r  <= '0;
      running_r <= 1'b0;
      split_r   <= 1'b0;
    end else if (fire) begin
      time_r    <= time_nxt;
      offset_r  <= offset_nxt;
      running_r <= running_nxt;
      split_r   <= split_nxt;
    end
  end

endmodule

>>> rtl/vehicle_performance_timer_unit.sv
// Top level of the vehicle performance timer: input stage, state update and result register.
// The input register takes each word; the state update then loads the result and out_valid.
// Throughput: one word per cycle while results are taken; speed times elapsed is formed on
// the way into the input register, and the state update plus saturation fill the stage after
// it. A result not taken holds the input stage, so in_ready falls once both stages hold a word.
// Reset (rst_n low, synchronous) clears run, stopwatch and both stages, loads register defaults.
module vehicle_performance_timer_unit #(
  parameter int TIME_BITS = vpt_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vpt_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vpt_pkg::out_word_t               out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vpt_pkg::*;

  // Configuration registers. Writes are always taken; an index past the
  // list is simply dropped.
  run_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_speed       <= START_SPEED_RST;
      cfg_r.first_speed_mark  <= FIRST_MARK_RST;
      cfg_r.second_speed_mark <= SECOND_MARK_RST;
      cfg_r.third_speed_mark  <= THIRD_MARK_RST;
      cfg_r.distance_limit    <= DIST_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_SPEED:    cfg_r.start_speed       <= cfg_data[SPEED_W-1:0];
        CFG_FIRST_MARK:     cfg_r.first_speed_mark  <= cfg_data[SPEED_W-1:0];
        CFG_SECOND_MARK:    cfg_r.second_speed_mark <= cfg_data[SPEED_W-1:0];
        CFG_THIRD_MARK:     cfg_r.third_speed_mark  <= cfg_data[SPEED_W-1:0];
        CFG_DISTANCE_LIMIT: cfg_r.distance_limit    <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control. The input stage moves on whenever the result register
  // is empty or being emptied, so a new word can enter every cycle.
  logic     s1_v_r;
  in_word_t s1_word_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic     out_v_r;
  logic     advance;
  logic     fire;

  assign advance  = !out_v_r || out_ready;
  assign fire     = s1_v_r && advance;
  assign in_ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  // The product is only needed by ticks, but it is cheap to form for every word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
      s1_prod_r <= PROD_W'(in_word.elapsed_us) * PROD_W'(in_word.speed_mm_s);
    end
  end

  // State update units. Each reports its state after this word.
  logic [TIME_BITS-1:0] run_times [7];
  logic                 run_running;
  logic [3:0]           run_done;
  logic [TIME_BITS-1:0] watch_time;
  logic                 watch_running;

  vpt_run #(
    .TIME_BITS(TIME_BITS)
  ) u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .word       (s1_word_r),
    .prod       (s1_prod_r),
    .cfg        (cfg_r),
    .times_nxt  (run_times),
    .running_nxt(run_running),
    .done_nxt   (run_done)
  );

  vpt_watch #(
    .TIME_BITS(TIME_BITS)
  ) u_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .word       (s1_word_r),
    .time_nxt   (watch_time),
    .running_nxt(watch_running)
  );

  // Times wider than the output fields are clipped to all ones.
  function automatic logic [OUT_W-1:0] clip_out(input logic [TIME_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_W-1:0];
  endfunction

  out_word_t out_word_r;
  out_word_t out_word_nxt;

  always_comb begin
    out_word_nxt.time_to_first        = clip_out(run_times[0]);
    out_word_nxt.time_to_second       = clip_out(run_times[1]);
    out_word_nxt.time_to_third        = clip_out(run_times[2]);
    out_word_nxt.time_first_to_second = clip_out(run_times[3]);
    out_word_nxt.time_first_to_third  = clip_out(run_times[4]);
    out_word_nxt.time_second_to_third = clip_out(run_times[5]);
    out_word_nxt.quarter_mile_time    = clip_out(run_times[6]);
    out_word_nxt.stopwatch_time       = clip_out(watch_time);
    out_word_nxt.run_active           = run_running;
    out_word_nxt.marks_done           = run_done;
    out_word_nxt.stopwatch_active     = watch_running;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/vpt_checker.sv
// Port-level assertions for the vehicle performance timer, bound to the top level.
module vpt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input vpt_pkg::out_word_t out_word
);
  import vpt_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  // With no result waiting, the input side is always open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while no result is waiting");

  // Without a running run nothing has been timed or marked.
  a_idle_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.run_active |->
      out_word.marks_done == 4'd0 && out_word.time_to_first == '0 &&
      out_word.quarter_mile_time == '0)
    else $error("run state present while run is not active");

  // A difference timer never exceeds the total it is taken from.
  a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.time_first_to_second <= out_word.time_to_second &&
      out_word.time_second_to_third <= out_word.time_to_third)
    else $error("difference timer above its total");

endmodule

bind vehicle_performance_timer_unit vpt_checker u_vpt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
